// ----- design/rotated_rect_corner_generator_macros.svh -----
// Assertion macros for the rotated rectangle corner generator RTL.
`ifndef ROTATED_RECT_CORNER_GENERATOR_MACROS_SVH
`define ROTATED_RECT_CORNER_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define RRC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define RRC_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg)
`define RRC_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ----- design/rrc_pkg.sv -----
// Types, constants and elaboration-time trig series for the corner generator.
`timescale 1ns / 1ps
`default_nettype none
package rrc_pkg;

    typedef logic signed [15:0] coord_t;
    typedef logic        [14:0] size_t;
    typedef logic signed [15:0] angle_t;
    typedef logic        [8:0]  deg_t;
    typedef logic        [6:0]  tbl_idx_t;

    localparam deg_t DEG_FULL    = 9'd360;
    localparam deg_t DEG_TRIPLE  = 9'd270;
    localparam deg_t DEG_HALF    = 9'd180;
    localparam deg_t DEG_QUARTER = 9'd90;

    // first-quadrant table holds 0..90 degrees inclusive
    localparam int TBL_DEPTH = 91;

    // angle splits into a signed high byte and an unsigned low byte
    localparam int ANG_LO_BITS  = 8;
    localparam int ANG_HI_DEPTH = 256;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q60_ONE      = 64'd1 << 60;
    localparam int          Q60_BITS     = 60;
    localparam int          TAYLOR_TERMS = 12;

    // sin(k degrees) in Q60 by Taylor series; evaluated at elaboration only
    function automatic logic [63:0] sin_q60(input int unsigned k);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        x    = (PI_Q60 / 64'(DEG_HALF)) * 64'(k);
        prod = 128'(x) * 128'(x);
        x2   = prod[123:60];
        term = x;
        sum  = x;
        for (int unsigned n = 1; n <= TAYLOR_TERMS; n++)
        begin
            prod = 128'(term) * 128'(x2);
            term = prod[123:60] / 64'((2 * n) * (2 * n + 1));
            if (n[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (sum > Q60_ONE)
        begin
            sum = Q60_ONE;
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

// ----- design/rrc_in_if.sv -----
// Sprite description channel: valid/ready plus centre, size and angle.
`timescale 1ns / 1ps
`default_nettype none
interface rrc_in_if;
    import rrc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t centre_x;
    coord_t centre_y;
    size_t  quad_width;
    size_t  quad_height;
    angle_t angle_deg;

    modport source (
        output valid, centre_x, centre_y, quad_width, quad_height, angle_deg,
        input  ready
    );

    modport sink (
        input  valid, centre_x, centre_y, quad_width, quad_height, angle_deg,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/rrc_out_if.sv -----
// Corner channel: valid/ready plus the four rotated corners.
`timescale 1ns / 1ps
`default_nettype none
interface rrc_out_if;
    import rrc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t top_left_x;
    coord_t top_left_y;
    coord_t bottom_left_x;
    coord_t bottom_left_y;
    coord_t top_right_x;
    coord_t top_right_y;
    coord_t bottom_right_x;
    coord_t bottom_right_y;

    modport source (
        output valid, top_left_x, top_left_y, bottom_left_x, bottom_left_y,
               top_right_x, top_right_y, bottom_right_x, bottom_right_y,
        input  ready
    );

    modport sink (
        input  valid, top_left_x, top_left_y, bottom_left_x, bottom_left_y,
               top_right_x, top_right_y, bottom_right_x, bottom_right_y,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/rrc_trig_lut.sv -----
// Cosine and sine of a reduced angle from a first-quadrant constant table.
`timescale 1ns / 1ps
`default_nettype none
module rrc_trig_lut #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire rrc_pkg::deg_t                       ang,
    output logic signed [TRIG_FRAC_BITS+1:0]         cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0]         sin_val
);
    import rrc_pkg::*;

    localparam int          SHIFT = Q60_BITS - TRIG_FRAC_BITS;
    localparam logic [63:0] RND   = 64'd1 << (SHIFT - 1);

    logic [TRIG_FRAC_BITS:0] sin_tbl [TBL_DEPTH];

    // build the table: round the Q60 series half up to the target fraction bits
    for (genvar g = 0; g < TBL_DEPTH; g++)
    begin : g_tbl
        localparam logic [63:0] ROUNDED = sin_q60(g) + RND;
        assign sin_tbl[g] = ROUNDED[SHIFT +: TRIG_FRAC_BITS + 1];
    end

    deg_t     sin_off;
    deg_t     cos_off;
    tbl_idx_t sin_idx;
    tbl_idx_t cos_idx;
    logic     sin_neg;
    logic     cos_neg;
    logic signed [TRIG_FRAC_BITS+1:0] sin_mag;
    logic signed [TRIG_FRAC_BITS+1:0] cos_mag;

    // fold the angle into the first quadrant and pick signs
    always_comb
    begin
        priority if (ang <= DEG_QUARTER)
        begin
            sin_off = ang;
            cos_off = DEG_QUARTER - ang;
            sin_neg = 1'b0;
            cos_neg = 1'b0;
        end
        else if (ang <= DEG_HALF)
        begin
            sin_off = DEG_HALF - ang;
            cos_off = ang - DEG_QUARTER;
            sin_neg = 1'b0;
            cos_neg = 1'b1;
        end
        else if (ang <= DEG_TRIPLE)
        begin
            sin_off = ang - DEG_HALF;
            cos_off = DEG_TRIPLE - ang;
            sin_neg = 1'b1;
            cos_neg = 1'b1;
        end
        else
        begin
            sin_off = DEG_FULL - ang;
            cos_off = ang - DEG_TRIPLE;
            sin_neg = 1'b1;
            cos_neg = 1'b0;
        end
        sin_idx = sin_off[6:0];
        cos_idx = cos_off[6:0];
    end

    // look up and apply signs
    assign sin_mag = $signed({1'b0, sin_tbl[sin_idx]});
    assign cos_mag = $signed({1'b0, sin_tbl[cos_idx]});
    assign sin_val = sin_neg ? -sin_mag : sin_mag;
    assign cos_val = cos_neg ? -cos_mag : cos_mag;

endmodule
`default_nettype wire

// ----- design/rotated_rect_corner_generator.sv -----
// Top level: four-stage pipeline from sprite description to rotated corners.
`timescale 1ns / 1ps
`default_nettype none
// Rotated rectangle corner generator. Each sprite transaction (centre, width,
// height, whole-degree angle) yields one corner transaction, presented from
// the output register; a new sprite is taken every cycle unless the full
// pipeline waits on the output. The four register stages hold the sprite
// with its reduced angle, the trig table lookup, the four size-by-trig
// multiplies, and the sums with truncation toward zero; each stage has its
// own ready, so empty stages fill while the output waits. The angle is
// reduced modulo 360, cosine and sine are rounded to TRIG_FRAC_BITS fraction
// bits, half sizes keep one fraction bit, and corners wrap to 16 bits.
module rotated_rect_corner_generator #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire  clk,
    input  wire  rst_n,
    rrc_in_if.sink     sprite,
    rrc_out_if.source  corners
);
    import rrc_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;   // signed trig width
    localparam int PW = TW + 16;              // signed product width
    localparam int SW = PW + 1;               // signed sum width
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(64'd1 << TRIG_FRAC_BITS);
    localparam logic signed [SW-1:0] TRUNC_BIAS =
        SW'((64'd1 << (TRIG_FRAC_BITS + 1)) - 64'd1);

    // truncate toward zero, drop the fraction, add centre, wrap
    function automatic coord_t place(input logic signed [SW-1:0] sum, input coord_t centre);
        logic signed [SW-1:0] adj;
        logic signed [SW-1:0] whole;
        adj   = sum + (sum[SW-1] ? TRUNC_BIAS : '0);
        whole = adj >>> (TRIG_FRAC_BITS + 1);
        return coord_t'(whole[15:0] + centre);
    endfunction

    // ------------------------------------------------------------------
    // Angle reduction: signed high byte by table, low byte added, one subtract
    // ------------------------------------------------------------------
    deg_t        mod_hi [ANG_HI_DEPTH];
    logic [9:0]  ang_sum;
    deg_t        ang_red;

    // high byte weighs a signed multiple of 256 degrees; hold it mod 360
    for (genvar g = 0; g < ANG_HI_DEPTH; g++)
    begin : g_mod
        localparam int HI_SIGNED = (g < ANG_HI_DEPTH / 2) ? g : g - ANG_HI_DEPTH;
        localparam int MODV = ((HI_SIGNED * ANG_HI_DEPTH) % int'(DEG_FULL)
                               + int'(DEG_FULL)) % int'(DEG_FULL);
        assign mod_hi[g] = deg_t'(MODV);
    end

    always_comb
    begin
        ang_sum = {1'b0, mod_hi[sprite.angle_deg[15:ANG_LO_BITS]]}
                + {2'b00, sprite.angle_deg[ANG_LO_BITS-1:0]};
        if (ang_sum >= 10'(DEG_FULL))
        begin
            ang_red = deg_t'(ang_sum - 10'(DEG_FULL));
        end
        else
        begin
            ang_red = ang_sum[8:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage moves when empty or when the next moves
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;

    assign out_free     = !out_valid_reg || corners.ready;
    assign s3_ready     = !s3_valid_reg || out_free;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sprite.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sprite.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the sprite with its reduced angle
    // ------------------------------------------------------------------
    coord_t s1_cx_reg;
    coord_t s1_cy_reg;
    size_t  s1_w_reg;
    size_t  s1_h_reg;
    deg_t   s1_ang_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && sprite.valid)
        begin
            s1_cx_reg  <= sprite.centre_x;
            s1_cy_reg  <= sprite.centre_y;
            s1_w_reg   <= sprite.quad_width;
            s1_h_reg   <= sprite.quad_height;
            s1_ang_reg <= ang_red;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cosine and sine
    // ------------------------------------------------------------------
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_next;
    logic signed [TW-1:0] s2_cos_reg;
    logic signed [TW-1:0] s2_sin_reg;
    coord_t s2_cx_reg;
    coord_t s2_cy_reg;
    size_t  s2_w_reg;
    size_t  s2_h_reg;

    rrc_trig_lut #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .ang     (s1_ang_reg),
        .cos_val (cos_next),
        .sin_val (sin_next)
    );

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_cos_reg <= cos_next;
            s2_sin_reg <= sin_next;
            s2_cx_reg  <= s1_cx_reg;
            s2_cy_reg  <= s1_cy_reg;
            s2_w_reg   <= s1_w_reg;
            s2_h_reg   <= s1_h_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: four products, sizes read as Q1 half sizes
    // ------------------------------------------------------------------
    logic signed [15:0]   w_s;
    logic signed [15:0]   h_s;
    logic signed [PW-1:0] cw_next;
    logic signed [PW-1:0] ch_next;
    logic signed [PW-1:0] sw_next;
    logic signed [PW-1:0] sh_next;
    logic signed [PW-1:0] s3_cw_reg;
    logic signed [PW-1:0] s3_ch_reg;
    logic signed [PW-1:0] s3_sw_reg;
    logic signed [PW-1:0] s3_sh_reg;
    coord_t s3_cx_reg;
    coord_t s3_cy_reg;

    assign w_s     = $signed({1'b0, s2_w_reg});
    assign h_s     = $signed({1'b0, s2_h_reg});
    assign cw_next = PW'(s2_cos_reg * w_s);
    assign ch_next = PW'(s2_cos_reg * h_s);
    assign sw_next = PW'(s2_sin_reg * w_s);
    assign sh_next = PW'(s2_sin_reg * h_s);

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_cw_reg <= cw_next;
            s3_ch_reg <= ch_next;
            s3_sw_reg <= sw_next;
            s3_sh_reg <= sh_next;
            s3_cx_reg <= s2_cx_reg;
            s3_cy_reg <= s2_cy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sums, truncation and placement into the output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] cw_e;
    logic signed [SW-1:0] ch_e;
    logic signed [SW-1:0] sw_e;
    logic signed [SW-1:0] sh_e;
    coord_t tlx_reg;
    coord_t tly_reg;
    coord_t blx_reg;
    coord_t bly_reg;
    coord_t trx_reg;
    coord_t try_reg;
    coord_t brx_reg;
    coord_t bry_reg;

    assign cw_e = SW'(s3_cw_reg);
    assign ch_e = SW'(s3_ch_reg);
    assign sw_e = SW'(s3_sw_reg);
    assign sh_e = SW'(s3_sh_reg);

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            tlx_reg <= place(-cw_e + sh_e, s3_cx_reg);
            tly_reg <= place(-ch_e - sw_e, s3_cy_reg);
            blx_reg <= place(-cw_e - sh_e, s3_cx_reg);
            bly_reg <= place( ch_e - sw_e, s3_cy_reg);
            trx_reg <= place( cw_e + sh_e, s3_cx_reg);
            try_reg <= place(-ch_e + sw_e, s3_cy_reg);
            brx_reg <= place( cw_e - sh_e, s3_cx_reg);
            bry_reg <= place( ch_e + sw_e, s3_cy_reg);
        end
    end

    assign corners.valid          = out_valid_reg;
    assign corners.top_left_x     = tlx_reg;
    assign corners.top_left_y     = tly_reg;
    assign corners.bottom_left_x  = blx_reg;
    assign corners.bottom_left_y  = bly_reg;
    assign corners.top_right_x    = trx_reg;
    assign corners.top_right_y    = try_reg;
    assign corners.bottom_right_x = brx_reg;
    assign corners.bottom_right_y = bry_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "rotated_rect_corner_generator_macros.svh"

    `RRC_ASSERT_IMP(a_ang_reduced, clk, rst_n, s1_valid_reg, s1_ang_reg < DEG_FULL, "reduced angle out of range")
    `RRC_ASSERT_IMP(a_trig_bound, clk, rst_n, s2_valid_reg, (s2_cos_reg <= TRIG_ONE) && (s2_cos_reg >= -TRIG_ONE) && (s2_sin_reg <= TRIG_ONE) && (s2_sin_reg >= -TRIG_ONE), "trig value beyond unity")
    `RRC_ASSERT_NXT(a_accept_fills, clk, rst_n, sprite.valid && sprite.ready, s1_valid_reg, "accepted transaction lost at stage one")

endmodule
`default_nettype wire
